>>> hdl/button_click_classifier_unit_macros.svh
// ---------------------------------------------------------------------------
// Button click classifier assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication.
`define BCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("button click classifier check failed");

// Next-cycle implication.
`define BCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("button click classifier check failed");

`endif

>>> hdl/bcc_pkg.sv
// ---------------------------------------------------------------------------
// Button click classifier package
// Constants, beat types and event codes shared by the classifier modules.
// ---------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  localparam int NUM_KEYS  = 2;
  localparam int KEY_BITS  = 2;
  localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = CFG_W'(1000);
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = CFG_W'(300);

  typedef enum logic [1:0] {
    EV_SHORT  = 2'd0,
    EV_LONG   = 2'd1,
    EV_DOUBLE = 2'd2
  } bcc_kind_e;

  typedef enum logic {
    REG_LONG_PRESS   = 1'b0,
    REG_DOUBLE_CLICK = 1'b1
  } bcc_reg_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] keys_down;
    logic [STAMP_W-1:0]  now_ms;
  } bcc_in_t;

  typedef struct packed {
    logic       key_index;
    logic [1:0] event_kind;
    logic       last_event;
  } bcc_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_click_ms;
  } bcc_cfg_t;

  // Events of one scan: one hit bit and one kind per key.
  typedef struct packed {
    logic [NUM_KEYS-1:0]      hit;
    logic [NUM_KEYS-1:0][1:0] kind;
  } bcc_rec_t;

endpackage

`default_nettype wire

>>> hdl/bcc_front.sv
// ---------------------------------------------------------------------------
// Button click classifier front end
// Takes scan beats, tracks per-key level, press time and click count, and
// hands each scan's events to the queue as one record.
// ---------------------------------------------------------------------------
`default_nettype none

module bcc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bcc_pkg::bcc_in_t  in_data_i,
  input  bcc_pkg::bcc_cfg_t cfg_i,
  input  logic              q_full_i,
  output logic              push_o,
  output bcc_pkg::bcc_rec_t rec_o
);
  import bcc_pkg::*;

  logic [NUM_KEYS-1:0]              prior_q, prior_d;
  logic [NUM_KEYS-1:0][STAMP_W-1:0] stamp_q, stamp_d;
  logic [NUM_KEYS-1:0][1:0]         clicks_q, clicks_d;
  logic [NUM_KEYS-1:0]              level;
  logic [NUM_KEYS-1:0][STAMP_W-1:0] held;
  logic [NUM_KEYS-1:0][1:0]         clicks_n;
  logic [STAMP_W-1:0]               long_lim;
  logic [STAMP_W-1:0]               dbl_lim;
  logic                             accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign level      = NUM_KEYS'(in_data_i.keys_down);
  assign long_lim   = {{(STAMP_W-CFG_W){1'b0}}, cfg_i.long_press_ms};
  assign dbl_lim    = {{(STAMP_W-CFG_W){1'b0}}, cfg_i.double_click_ms};

  always_comb begin
    rec_o    = '0;
    prior_d  = prior_q;
    stamp_d  = stamp_q;
    clicks_d = clicks_q;
    clicks_n = clicks_q;
    for (int k = 0; k < NUM_KEYS; k++) begin
      held[k] = in_data_i.now_ms - stamp_q[k];
      rec_o.kind[k] = EV_SHORT;
      if (level[k] && !prior_q[k]) begin
        if (clicks_q[k] < 2'd2) begin
          clicks_n[k] = clicks_q[k] + 2'd1;
        end
      end else if (!level[k] && prior_q[k]) begin
        if (clicks_q[k] >= 2'd2) begin
          rec_o.hit[k]  = 1'b1;
          rec_o.kind[k] = EV_DOUBLE;
          clicks_n[k]   = 2'd0;
        end else if (clicks_q[k] == 2'd1 && held[k] > long_lim) begin
          rec_o.hit[k]  = 1'b1;
          rec_o.kind[k] = EV_LONG;
          clicks_n[k]   = 2'd0;
        end
      end
      if (clicks_n[k] == 2'd1 && !level[k] && held[k] > dbl_lim) begin
        rec_o.hit[k]  = 1'b1;
        rec_o.kind[k] = EV_SHORT;
        clicks_n[k]   = 2'd0;
      end
      if (accept) begin
        prior_d[k]  = level[k];
        clicks_d[k] = clicks_n[k];
        if (level[k] && !prior_q[k]) begin
          stamp_d[k] = in_data_i.now_ms;
        end
      end
    end
  end

  assign push_o = accept && (|rec_o.hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q  <= '0;
      stamp_q  <= '0;
      clicks_q <= '0;
    end else begin
      prior_q  <= prior_d;
      stamp_q  <= stamp_d;
      clicks_q <= clicks_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bcc_queue.sv
// ---------------------------------------------------------------------------
// Button click classifier record queue
// Two-entry queue of scan records between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module bcc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bcc_pkg::bcc_rec_t rec_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output bcc_pkg::bcc_rec_t rec_o
);
  import bcc_pkg::*;

  bcc_rec_t   mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bcc_back.sv
// ---------------------------------------------------------------------------
// Button click classifier back end
// Sends the events of the head record one per beat in ascending key order
// through an output register, marking the final event of each scan.
// ---------------------------------------------------------------------------
`default_nettype none

module bcc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  bcc_pkg::bcc_rec_t rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bcc_pkg::bcc_out_t out_data_o
);
  import bcc_pkg::*;

  logic [NUM_KEYS-1:0]  done_q, done_d;
  logic [NUM_KEYS-1:0]  pending;
  logic [NUM_KEYS-1:0]  sel_oh;
  logic [NUM_KEYS-1:0]  rest;
  logic [KEY_IDX_W-1:0] sel;
  logic                 load;
  logic                 out_valid_q;
  bcc_out_t             out_q;

  assign pending = rec_i.hit & ~done_q;

  always_comb begin
    sel = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (pending[k]) begin
        sel = KEY_IDX_W'(k);
      end
    end
  end

  assign sel_oh = NUM_KEYS'(1) << sel;
  assign rest   = pending & ~sel_oh;
  assign load   = q_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o  = load && (rest == '0);

  always_comb begin
    done_d = done_q;
    if (load) begin
      done_d = (rest == '0) ? '0 : (done_q | sel_oh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.key_index  <= sel[0];
      out_q.event_kind <= rec_i.kind[sel];
      out_q.last_event <= (rest == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hdl/button_click_classifier_unit.sv
// ---------------------------------------------------------------------------
// Button click classifier
// Classifies key scans into short press, long press and double click events,
// each sent as one beat tagged with its key index.
// ---------------------------------------------------------------------------
//  Port group  Direction  Beat content
//  in_*        input      keys_down, now_ms (one scan)
//  out_*       output     key_index, event_kind, last_event (one event)
//  APB         input      long_press_ms at 0x0, double_click_ms at 0x4
//
//  A scan is taken in the cycle it arrives while the two-entry queue has room.
//  The back end sends one event per cycle while the output is not stalled, and
//  pops a scan only with its last event; with two keys a scan has at most two events.
//  Reset sets the limits to 1000 and 300 ms and clears all key state.
//  A stalled output holds its event while further scans are taken until the queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module button_click_classifier_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bcc_pkg::bcc_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bcc_pkg::bcc_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bcc_pkg::ADDR_W-1:0]    paddr,
  input  logic [bcc_pkg::DATA_W-1:0]    pwdata,
  output logic [bcc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import bcc_pkg::*;

  bcc_cfg_t cfg_q;
  bcc_reg_e reg_sel;
  logic     cfg_wr;
  logic     q_full;
  logic     q_valid;
  logic     push;
  logic     pop;
  bcc_rec_t rec_in;
  bcc_rec_t rec_head;

  assign pready  = 1'b1;
  assign reg_sel = bcc_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_LONG_PRESS:   prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.long_press_ms};
      REG_DOUBLE_CLICK: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.double_click_ms};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms   <= LONG_PRESS_RESET;
      cfg_q.double_click_ms <= DOUBLE_CLICK_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_LONG_PRESS:   cfg_q.long_press_ms   <= pwdata[CFG_W-1:0];
        REG_DOUBLE_CLICK: cfg_q.double_click_ms <= pwdata[CFG_W-1:0];
        default:          cfg_q                 <= cfg_q;
      endcase
    end
  end

  bcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  bcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (rec_head)
  );

  bcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .rec_i       (rec_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> hdl/bcc_checker.sv
// ---------------------------------------------------------------------------
// Button click classifier port checker
// Watches the top-level ports for output hold, event run continuity, zero upper
// read bits and register read-back, and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_click_classifier_unit_macros.svh"

module bcc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input bcc_pkg::bcc_out_t          out_data_o,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [bcc_pkg::ADDR_W-1:0] paddr,
  input logic [bcc_pkg::DATA_W-1:0] pwdata,
  input logic [bcc_pkg::DATA_W-1:0] prdata
);
  import bcc_pkg::*;

  `BCC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  `BCC_ASSERT_NEXT(a_scan_run, out_valid_o && !out_stall_i && !out_data_o.last_event, out_valid_o)

  `BCC_ASSERT_NOW(a_rd_upper, psel && !pwrite, prdata[DATA_W-1:CFG_W] == '0)

  `BCC_ASSERT_NOW(a_rd_back, (psel && penable && pwrite) ##1 (psel && !pwrite && paddr[2] == $past(paddr[2])), prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

`default_nettype wire
